### rtl/core/lik_pkg.sv
// Shared types, constants and arithmetic steps for the leg inverse kinematics block.
package lik_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int CORDIC_STAGES = 16;

  // target fields are sign-extended from this many bits
  localparam int IN_W = (DATA_WIDTH < 2) ? 2 : ((DATA_WIDTH > 16) ? 16 : DATA_WIDTH);
  localparam int CS   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  localparam logic signed [34:0] PI_Q30  = 35'sd3373259426;
  localparam logic signed [14:0] PI_Q12  = 15'sd12868;
  localparam logic [12:0]        ONE_Q12 = 13'd4096;

  localparam logic [14:0] COXA_LEN_RST  = 15'd2048;
  localparam logic [14:0] FEMUR_LEN_RST = 15'd2048;
  localparam logic [14:0] TIBIA_LEN_RST = 15'd2048;
  localparam logic [14:0] LIFT_HGT_RST  = 15'd1434;

  // register index, byte address is 4x this
  typedef enum logic [1:0] {
    REG_COXA  = 2'd0,
    REG_FEMUR = 2'd1,
    REG_TIBIA = 2'd2,
    REG_LIFT  = 2'd3
  } lik_reg_e;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic               lift;
  } lik_in_t;

  typedef struct packed {
    logic signed [14:0] coxa_angle;
    logic signed [15:0] femur_angle;
    logic [13:0]        tibia_angle;
    logic               unreachable;
  } lik_out_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] root;
  } lik_sqrt_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [12:0] quo;
  } lik_div_t;

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // one digit of a floor square root
  function automatic lik_sqrt_t sqrt_step(input lik_sqrt_t s, input logic [31:0] b);
    lik_sqrt_t   r;
    logic [32:0] trial;
    trial = {1'b0, s.root} + {1'b0, b};
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[31:0];
      r.root = (s.root >> 1) + b;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // one quotient bit of a restoring division
  function automatic lik_div_t div_step(input lik_div_t s, input logic [31:0] den);
    lik_div_t    r;
    logic        ge;
    logic [32:0] diff;
    ge     = (s.rem >= {1'b0, den});
    diff   = ge ? (s.rem - {1'b0, den}) : s.rem;
    r.rem  = {diff[31:0], 1'b0};
    r.quo  = {s.quo[11:0], ge};
    return r;
  endfunction

endpackage

### rtl/core/lik_if.sv
// Valid/ready channel interfaces for target and joint angle transfers.
interface lik_in_if import lik_pkg::*; ();
  logic    valid;
  logic    ready;
  lik_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lik_out_if import lik_pkg::*; ();
  logic     valid;
  logic     ready;
  lik_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/leg_inverse_kinematics_3dof_top.sv
// Top level of the three-joint leg inverse kinematics pipeline with its APB register file.
// A target (x, y, lift) transfers in on in_i and its three joint angles plus the unreachable
// flag leave on out_o; one target is taken every cycle while out_o is not stalled. The stages in
// line are 16 square-root digits for the reach, 16 for the span, 13 quotient bits for the
// law-of-cosines ratios, 13 square-root digits for the acos sine term, and an 18-stage CORDIC
// (prescale, 16 iterations, rounding) shared in form by all four angles, plus the product and
// output registers. When out_o is stalled the whole pipeline holds and in_i.ready drops in the
// same cycle. Link lengths and lift height must be written over APB only while the pipeline
// is empty; the block itself does not enforce this.
module leg_inverse_kinematics_3dof_top import lik_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lik_in_if.sink      in_i,
  lik_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SQ1_N   = 16;
  localparam int SQ2_N   = 16;
  localparam int DIV_N   = 13;
  localparam int SQ3_N   = 13;
  localparam int CL      = CS + 2;
  localparam int P_SUM1  = 1;
  localparam int P_R     = P_SUM1 + SQ1_N;
  localparam int P_H     = P_R + 1;
  localparam int P_SUM2  = P_H + 1;
  localparam int P_S     = P_SUM2 + SQ2_N;
  localparam int P_PROD  = P_S + 1;
  localparam int P_RATIO = P_PROD + 1;
  localparam int P_Q     = P_RATIO + DIV_N;
  localparam int P_C     = P_Q + 1;
  localparam int P_SN    = P_C + SQ3_N;
  localparam int P_ANG   = P_SN + CL;
  localparam int P_OUT   = P_ANG + 1;

  // ---------------- registers ----------------
  logic [14:0] coxa_len_q, femur_len_q, tibia_len_q, lift_hgt_q;
  lik_reg_e    reg_sel;

  assign reg_sel = lik_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coxa_len_q  <= COXA_LEN_RST;
      femur_len_q <= FEMUR_LEN_RST;
      tibia_len_q <= TIBIA_LEN_RST;
      lift_hgt_q  <= LIFT_HGT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_COXA:  coxa_len_q  <= pwdata[14:0];
        REG_FEMUR: femur_len_q <= pwdata[14:0];
        REG_TIBIA: tibia_len_q <= pwdata[14:0];
        REG_LIFT:  lift_hgt_q  <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COXA:  prdata = {17'd0, coxa_len_q};
      REG_FEMUR: prdata = {17'd0, femur_len_q};
      REG_TIBIA: prdata = {17'd0, tibia_len_q};
      REG_LIFT:  prdata = {17'd0, lift_hgt_q};
    endcase
  end

  // ---------------- valid chain ----------------
  logic [P_OUT:0] vld_q;
  logic           adv;

  assign adv         = !vld_q[P_OUT] || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = vld_q[P_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[P_OUT-1:0], in_i.valid};
    end
  end

  // ---------------- side data lines ----------------
  logic signed [15:0] x_q [0:P_SN];
  logic signed [15:0] y_q [0:P_SN];
  logic               lift_q [0:P_R];
  logic signed [16:0] h_q [P_H:P_SN];
  logic [14:0]        dz_q [P_H:P_SN];
  logic               fl_q [P_PROD:P_ANG];

  logic signed [15:0] x_in, y_in;

  assign x_in = 16'(signed'(in_i.data.target_x[IN_W-1:0]));
  assign y_in = 16'(signed'(in_i.data.target_y[IN_W-1:0]));

  // ---------------- reach: sqrt(x^2 + y^2) ----------------
  lik_sqrt_t          sq1_q [P_SUM1:P_R];
  logic signed [31:0] xx, yy;

  assign xx = x_q[0] * x_q[0];
  assign yy = y_q[0] * y_q[0];

  // ---------------- span: sqrt(h^2 + dz^2) ----------------
  lik_sqrt_t          sq2_q [P_SUM2:P_S];
  logic signed [16:0] h_d;
  logic signed [33:0] hh;
  logic [29:0]        dd;
  logic [15:0]        span;

  assign h_d  = signed'({1'b0, sq1_q[P_R].root[15:0]}) - signed'({2'b0, coxa_len_q});
  assign hh   = h_q[P_H] * h_q[P_H];
  assign dd   = dz_q[P_H] * dz_q[P_H];
  assign span = sq2_q[P_S].root[15:0];

  // ---------------- law of cosines ----------------
  logic [29:0] ff_q, tt_q, ft_q;
  logic [31:0] ss_q;
  logic [30:0] sf_q;

  logic signed [34:0] num_c [2];
  logic [31:0]        den_c [2];
  logic [32:0]        n0_c  [2];
  logic [31:0]        d0_c  [2];
  logic               neg_c [2];
  logic               rfl_c [2];

  lik_div_t    dv_q [2][P_RATIO:P_Q];
  logic [31:0] dd_q [2][P_RATIO:P_Q];
  logic        dn_q [2][P_RATIO:P_Q];

  always_comb begin
    num_c[0] = 35'(ff_q) + 35'(ss_q) - 35'(tt_q);
    den_c[0] = {sf_q, 1'b0};
    num_c[1] = 35'(ff_q) + 35'(tt_q) - 35'(ss_q);
    den_c[1] = {1'b0, ft_q, 1'b0};
    for (int j = 0; j < 2; j++) begin
      // clamped arguments reuse the divider with numerator equal to denominator
      if (den_c[j] == '0) begin
        n0_c[j]  = 33'd1;
        d0_c[j]  = 32'd1;
        neg_c[j] = 1'b0;
        rfl_c[j] = 1'b1;
      end else if (num_c[j] > signed'({3'b0, den_c[j]})) begin
        n0_c[j]  = {1'b0, den_c[j]};
        d0_c[j]  = den_c[j];
        neg_c[j] = 1'b0;
        rfl_c[j] = 1'b1;
      end else if (num_c[j] < -signed'({3'b0, den_c[j]})) begin
        n0_c[j]  = {1'b0, den_c[j]};
        d0_c[j]  = den_c[j];
        neg_c[j] = 1'b1;
        rfl_c[j] = 1'b1;
      end else if (num_c[j] >= 0) begin
        n0_c[j]  = num_c[j][32:0];
        d0_c[j]  = den_c[j];
        neg_c[j] = 1'b0;
        rfl_c[j] = 1'b0;
      end else begin
        n0_c[j]  = 33'(-num_c[j]);
        d0_c[j]  = den_c[j];
        neg_c[j] = 1'b1;
        rfl_c[j] = 1'b0;
      end
    end
  end

  // ---------------- acos sine term: sqrt(1 - c^2) ----------------
  logic signed [13:0] c_q   [2][P_C:P_SN];
  lik_sqrt_t          sq3_q [2][P_C:P_SN];

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0]    <= x_in;
      y_q[0]    <= y_in;
      lift_q[0] <= in_i.data.lift;
      for (int k = 1; k <= P_SN; k++) begin
        x_q[k] <= x_q[k-1];
        y_q[k] <= y_q[k-1];
      end
      for (int k = 1; k <= P_R; k++) begin
        lift_q[k] <= lift_q[k-1];
      end

      sq1_q[P_SUM1] <= '{rem: 32'(xx) + 32'(yy), root: '0};
      for (int k = 0; k < SQ1_N; k++) begin
        sq1_q[P_SUM1+k+1] <= sqrt_step(sq1_q[P_SUM1+k], 32'(1) << (2 * (SQ1_N - 1 - k)));
      end

      h_q[P_H]  <= h_d;
      dz_q[P_H] <= lift_q[P_R] ? lift_hgt_q : '0;
      for (int k = P_H + 1; k <= P_SN; k++) begin
        h_q[k]  <= h_q[k-1];
        dz_q[k] <= dz_q[k-1];
      end

      sq2_q[P_SUM2] <= '{rem: hh[31:0] + 32'(dd), root: '0};
      for (int k = 0; k < SQ2_N; k++) begin
        sq2_q[P_SUM2+k+1] <= sqrt_step(sq2_q[P_SUM2+k], 32'(1) << (2 * (SQ2_N - 1 - k)));
      end

      ff_q         <= femur_len_q * femur_len_q;
      tt_q         <= tibia_len_q * tibia_len_q;
      ft_q         <= femur_len_q * tibia_len_q;
      ss_q         <= span * span;
      sf_q         <= span * femur_len_q;
      fl_q[P_PROD] <= (span == '0);

      fl_q[P_RATIO] <= fl_q[P_PROD] | rfl_c[0] | rfl_c[1];
      for (int k = P_RATIO + 1; k <= P_ANG; k++) begin
        fl_q[k] <= fl_q[k-1];
      end

      for (int j = 0; j < 2; j++) begin
        dv_q[j][P_RATIO] <= '{rem: n0_c[j], quo: '0};
        dd_q[j][P_RATIO] <= d0_c[j];
        dn_q[j][P_RATIO] <= neg_c[j];
        for (int k = 0; k < DIV_N; k++) begin
          dv_q[j][P_RATIO+k+1] <= div_step(dv_q[j][P_RATIO+k], dd_q[j][P_RATIO+k]);
          dd_q[j][P_RATIO+k+1] <= dd_q[j][P_RATIO+k];
          dn_q[j][P_RATIO+k+1] <= dn_q[j][P_RATIO+k];
        end

        c_q[j][P_C]   <= dn_q[j][P_Q] ? -signed'({1'b0, dv_q[j][P_Q].quo})
                                      :  signed'({1'b0, dv_q[j][P_Q].quo});
        sq3_q[j][P_C] <= '{rem: 32'(25'h1000000 - 25'(dv_q[j][P_Q].quo) *
                                                  25'(dv_q[j][P_Q].quo)),
                           root: '0};
        for (int k = 0; k < SQ3_N; k++) begin
          sq3_q[j][P_C+k+1] <= sqrt_step(sq3_q[j][P_C+k], 32'(1) << (2 * (SQ3_N - 1 - k)));
          c_q[j][P_C+k+1]   <= c_q[j][P_C+k];
        end
      end
    end
  end

  // ---------------- angles ----------------
  logic signed [14:0] coxa_ang, a1_ang, a2_ang, tib_ang;
  lik_out_t           out_q;

  lik_cordic u_coxa (
    .clk_i   (clk_i),
    .en_i    (adv),
    .y_i     (18'(y_q[P_SN])),
    .x_i     (18'(x_q[P_SN])),
    .angle_o (coxa_ang)
  );

  lik_cordic u_reach (
    .clk_i   (clk_i),
    .en_i    (adv),
    .y_i     (18'(h_q[P_SN])),
    .x_i     (signed'({3'b0, dz_q[P_SN]})),
    .angle_o (a1_ang)
  );

  lik_cordic u_femur (
    .clk_i   (clk_i),
    .en_i    (adv),
    .y_i     (signed'({5'b0, sq3_q[0][P_SN].root[12:0]})),
    .x_i     (18'(c_q[0][P_SN])),
    .angle_o (a2_ang)
  );

  lik_cordic u_tibia (
    .clk_i   (clk_i),
    .en_i    (adv),
    .y_i     (signed'({5'b0, sq3_q[1][P_SN].root[12:0]})),
    .x_i     (18'(c_q[1][P_SN])),
    .angle_o (tib_ang)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.coxa_angle  <= coxa_ang;
      out_q.femur_angle <= 16'(a1_ang) + 16'(a2_ang);
      out_q.tibia_angle <= tib_ang[13:0];
      out_q.unreachable <= fl_q[P_ANG];
    end
  end

  assign out_o.data = out_q;

  // ---------------- assertions ----------------
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_tib_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.tibia_angle <= 14'(PI_Q12)))
    else $error("tibia angle above pi");

  a_coxa_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.coxa_angle <= PI_Q12) && (out_o.data.coxa_angle >= -PI_Q12))
    else $error("coxa angle outside +-pi");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[P_Q] |-> (dv_q[0][P_Q].quo <= ONE_Q12) && (dv_q[1][P_Q].quo <= ONE_Q12))
    else $error("cosine magnitude above one");

  a_zero_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[P_S] && (span == '0) |=> fl_q[P_PROD])
    else $error("zero span not flagged");

endmodule

### rtl/core/lik_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in Q3.12.
module lik_cordic import lik_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [17:0] y_i,
  input  logic signed [17:0] x_i,
  output logic signed [14:0] angle_o
);

  localparam int XW = 40;
  localparam int ZW = 35;
  localparam logic signed [ZW-1:0] RND = ZW'(2**17);

  logic signed [XW-1:0] cx_q [0:CS];
  logic signed [XW-1:0] cy_q [0:CS];
  logic signed [ZW-1:0] cz_q [0:CS];
  logic                 zero_q [0:CS];

  logic signed [XW-1:0] x_ext, y_ext, x_pre, y_pre;
  logic signed [ZW-1:0] z_pre, z_sum, z_sh;
  logic signed [14:0]   angle_d;

  // left half-plane: rotate by pi first
  always_comb begin
    x_ext = XW'(x_i);
    y_ext = XW'(y_i);
    if (x_i < 0) begin
      x_pre = -x_ext;
      y_pre = -y_ext;
      z_pre = (y_i >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      x_pre = x_ext;
      y_pre = y_ext;
      z_pre = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0]   <= x_pre <<< 16;
      cy_q[0]   <= y_pre <<< 16;
      cz_q[0]   <= z_pre;
      zero_q[0] <= (x_i == 0) && (y_i == 0);
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cy_q[i][XW-1]) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - signed'({{(ZW-30){1'b0}}, atan_q30(5'(i))});
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + signed'({{(ZW-30){1'b0}}, atan_q30(5'(i))});
        end
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  // round Q2.30 to Q12 half up, then clamp to +-pi; a zero input vector gives zero
  always_comb begin
    z_sum = cz_q[CS] + RND;
    z_sh  = z_sum >>> 18;
    if (zero_q[CS]) begin
      angle_d = '0;
    end else if (z_sh > ZW'(PI_Q12)) begin
      angle_d = PI_Q12;
    end else if (z_sh < -ZW'(PI_Q12)) begin
      angle_d = -PI_Q12;
    end else begin
      angle_d = z_sh[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_o <= angle_d;
    end
  end

endmodule
